FILE: hw/rtl/acc_pkg.sv
package acc_pkg;

    localparam int MEM_WORDS = 32;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 8;
    localparam int OP_W      = 3;

    // Item commands
    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_EXEC    = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_NONE    = 2'd3
    } t_command;

    // Instruction opcodes, top three bits of a memory byte
    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 3'd0,
        OP_STORE = 3'd1,
        OP_ADD   = 3'd2,
        OP_SUB   = 3'd3,
        OP_INPUT = 3'd4,
        OP_JZ    = 3'd5,
        OP_JNN   = 3'd6,
        OP_HALT  = 3'd7
    } t_opcode;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_OPER = 2'd1,
        S_EXEC = 2'd2,
        S_DONE = 2'd3
    } t_state;

    // Memory address source
    typedef enum logic [1:0] {
        A_IN   = 2'd0,
        A_PC   = 2'd1,
        A_OPND = 2'd2
    } t_addr_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic      take_item;
        t_addr_sel addr_sel;
        logic      mem_rd;
        logic      mem_wr;
        logic      wr_acc;
        logic      restart;
        logic      decode;
        logic      alu;
        logic      out_load;
    } t_dp_ctl;

    // Datapath to controller status
    typedef struct packed {
        logic    halted;
        t_opcode op;
    } t_dp_sts;

endpackage

FILE: hw/rtl/acc_if.sv
interface acc_in_if
    import acc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [1:0]               command;
    logic [ADDR_W-1:0]        address;
    logic [DATA_W-1:0]        data_byte;
    logic signed [DATA_W-1:0] input_value;

    modport source (output valid, output command, output address, output data_byte,
                    output input_value, input ready);
    modport sink   (input valid, input command, input address, input data_byte,
                    input input_value, output ready);
endinterface

interface acc_out_if
    import acc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] accumulator;
    logic [ADDR_W-1:0]        program_counter;
    logic                     halted;
    logic                     took_input;

    modport source (output valid, output accumulator, output program_counter,
                    output halted, output took_input, input ready);
    modport sink   (input valid, input accumulator, input program_counter,
                    input halted, input took_input, output ready);
endinterface

FILE: hw/rtl/acc_ctrl.sv
module acc_ctrl
    import acc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_command i_in_command,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_sts  i_sts,
    output t_dp_ctl  o_ctl
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // State and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        o_ctl       = '0;
        o_ctl.addr_sel = A_PC;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.take_item = 1'b1;
                    n_state = S_DONE;
                    case (i_in_command)
                        CMD_WRITE: begin
                            o_ctl.addr_sel = A_IN;
                            o_ctl.mem_wr   = 1'b1;
                        end
                        CMD_EXEC: begin
                            // fetch the instruction at pc
                            if (!i_sts.halted) begin
                                o_ctl.addr_sel = A_PC;
                                o_ctl.mem_rd   = 1'b1;
                                n_state = S_OPER;
                            end
                        end
                        CMD_RESTART: o_ctl.restart = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_OPER: begin
                // advance pc, run register-only ops, start operand access
                o_ctl.decode   = 1'b1;
                o_ctl.addr_sel = A_OPND;
                n_state = S_DONE;
                case (i_sts.op)
                    OP_STORE: begin
                        o_ctl.mem_wr = 1'b1;
                        o_ctl.wr_acc = 1'b1;
                    end
                    OP_LOAD, OP_ADD, OP_SUB: begin
                        o_ctl.mem_rd = 1'b1;
                        n_state = S_EXEC;
                    end
                    default: ;
                endcase
            end
            S_EXEC: begin
                o_ctl.alu = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_ctl.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: hw/rtl/acc_dp.sv
module acc_dp
    import acc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_ctl                  i_ctl,
    output t_dp_sts                  o_sts,
    input  logic [ADDR_W-1:0]        i_address,
    input  logic [DATA_W-1:0]        i_data_byte,
    input  logic signed [DATA_W-1:0] i_input_value,
    output logic signed [DATA_W-1:0] o_accumulator,
    output logic [ADDR_W-1:0]        o_program_counter,
    output logic                     o_halted,
    output logic                     o_took_input
);

    logic [DATA_W-1:0]    r_mem [MEM_WORDS];
    logic [MEM_WORDS-1:0] r_valid;
    logic [DATA_W-1:0]    r_rdata;
    logic                 r_rvalid;

    logic [DATA_W-1:0] r_acc, n_acc;
    logic [ADDR_W-1:0] r_pc, n_pc;
    logic              r_halt, n_halt;
    logic              r_took, n_took;
    logic [DATA_W-1:0] r_in_value;
    t_opcode           r_op;

    logic signed [DATA_W-1:0] r_out_acc;
    logic [ADDR_W-1:0]        r_out_pc;
    logic                     r_out_halt;
    logic                     r_out_took;

    logic [DATA_W-1:0] w_rd;
    t_opcode           w_op;
    logic [ADDR_W-1:0] w_opnd;
    logic [ADDR_W-1:0] w_addr;
    logic [DATA_W-1:0] w_wdata;

    // Read data; never-written entries read as zero
    assign w_rd   = r_rvalid ? r_rdata : '0;
    assign w_op   = t_opcode'(w_rd[DATA_W-1 -: OP_W]);
    assign w_opnd = w_rd[ADDR_W-1:0];

    always_comb begin
        case (i_ctl.addr_sel)
            A_IN:    w_addr = i_address;
            A_PC:    w_addr = r_pc;
            A_OPND:  w_addr = w_opnd;
            default: w_addr = r_pc;
        endcase
    end

    assign w_wdata = i_ctl.wr_acc ? r_acc : i_data_byte;

    // Single-port memory with registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.mem_wr) begin
            r_mem[w_addr] <= w_wdata;
        end
        if (i_ctl.mem_rd) begin
            r_rdata <= r_mem[w_addr];
        end
    end

    // Entry valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_ctl.mem_wr) begin
                r_valid[w_addr] <= 1'b1;
            end
            if (i_ctl.mem_rd) begin
                r_rvalid <= r_valid[w_addr];
            end
        end
    end

    // Architectural register updates
    always_comb begin
        n_acc  = r_acc;
        n_pc   = r_pc;
        n_halt = r_halt;
        n_took = r_took;
        if (i_ctl.take_item) begin
            n_took = 1'b0;
        end
        if (i_ctl.restart) begin
            n_acc  = '0;
            n_pc   = '0;
            n_halt = 1'b0;
        end
        if (i_ctl.decode) begin
            n_pc = r_pc + ADDR_W'(1);
            case (w_op)
                OP_INPUT: begin
                    n_acc  = r_in_value;
                    n_took = 1'b1;
                end
                OP_JZ:   if (r_acc == '0) n_pc = w_opnd;
                OP_JNN:  if (!r_acc[DATA_W-1]) n_pc = w_opnd;
                OP_HALT: n_halt = 1'b1;
                default: ;
            endcase
        end
        if (i_ctl.alu) begin
            case (r_op)
                OP_LOAD: n_acc = w_rd;
                OP_ADD:  n_acc = r_acc + w_rd;
                OP_SUB:  n_acc = r_acc - w_rd;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_pc   <= '0;
            r_halt <= 1'b0;
            r_took <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_pc   <= n_pc;
            r_halt <= n_halt;
            r_took <= n_took;
        end
    end

    // Latch item input value and decoded opcode
    always_ff @(posedge i_clk) begin
        if (i_ctl.take_item) begin
            r_in_value <= i_input_value;
        end
        if (i_ctl.decode) begin
            r_op <= w_op;
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_out_acc  <= r_acc;
            r_out_pc   <= r_pc;
            r_out_halt <= r_halt;
            r_out_took <= r_took;
        end
    end

    assign o_sts.halted      = r_halt;
    assign o_sts.op          = w_op;
    assign o_accumulator     = r_out_acc;
    assign o_program_counter = r_out_pc;
    assign o_halted          = r_out_halt;
    assign o_took_input      = r_out_took;

endmodule

FILE: hw/rtl/accumulator_cpu_step.sv
// Channel  Dir  Word fields
// i_in     in   command, address, data_byte, input_value
// o_out    out  accumulator, program_counter, halted, took_input
//
// One command word at a time. Write, restart, unused command and execute while
// halted take 2 cycles; jump, input, store and halt take 3; load, add and
// subtract take 4, since the single-port memory serves the fetch and then the
// operand access. Reset is synchronous and clears pc, accumulator, halt flag and
// the 32 memory valid bits. A stalled output word holds the sequencer in its
// final state; the next command is still taken while a word waits.
module accumulator_cpu_step
    import acc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    acc_in_if.sink    i_in,
    acc_out_if.source o_out
);

    t_dp_ctl w_ctl;
    t_dp_sts w_sts;

    acc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_command (t_command'(i_in.command)),
        .o_in_ready   (i_in.ready),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .i_sts        (w_sts),
        .o_ctl        (w_ctl)
    );

    acc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (w_ctl),
        .o_sts             (w_sts),
        .i_address         (i_in.address),
        .i_data_byte       (i_in.data_byte),
        .i_input_value     (i_in.input_value),
        .o_accumulator     (o_out.accumulator),
        .o_program_counter (o_out.program_counter),
        .o_halted          (o_out.halted),
        .o_took_input      (o_out.took_input)
    );

    // Memory port serves one access a cycle
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctl.mem_wr && w_ctl.mem_rd))
        else $error("memory read and write in the same cycle");

    // Halt holds until a restart
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.halted && !w_ctl.restart |=> w_sts.halted)
        else $error("halt flag dropped without restart");

    // One command in flight
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("command taken while another is in flight");

    // Execute while halted touches no memory
    a_halt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && w_sts.halted && (i_in.command == CMD_EXEC)
        |-> !w_ctl.mem_rd && !w_ctl.mem_wr ##1 !w_ctl.mem_rd && !w_ctl.mem_wr)
        else $error("memory access while halted");

endmodule

FILE: dv/tb_accumulator_cpu_step.sv
module tb_accumulator_cpu_step;
    import acc_pkg::*;

    localparam int DIRECTED_WORDS = 28;
    localparam int RANDOM_WORDS   = 1400;
    localparam int TAIL_CYCLES    = 20;

    // One command word as queued for the driver
    typedef struct packed {
        t_command             cmd;
        logic [ADDR_W-1:0]    addr;
        logic [DATA_W-1:0]    data;
        logic [DATA_W-1:0]    in_val;
        logic                 drain_first;
    } t_cmd_word;

    // CPU state as reported by one result word
    typedef struct packed {
        logic [DATA_W-1:0]    acc;
        logic [ADDR_W-1:0]    pc;
        logic                 halted;
        logic                 took;
    } t_cpu_view;

    logic i_clk;
    logic i_rst_n;

    acc_in_if  in_bus ();
    acc_out_if out_bus ();

    accumulator_cpu_step i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // Shadow CPU state
    logic [DATA_W-1:0] shadow_mem [MEM_WORDS];
    logic [DATA_W-1:0] shadow_acc;
    logic [ADDR_W-1:0] shadow_pc;
    logic              shadow_halt;

    t_cmd_word cmd_words_q [$];
    t_cpu_view expected_views_q [$];

    int n_queued;
    int n_issued;
    int n_taken;
    int n_results;
    int n_errors;
    int n_exec;
    int n_halts;
    int n_inputs;

    // Driver and receiver pacing
    int burst_left;
    int gap_left;
    int stall_mode;
    int stall_seg;
    int stall_phase;
    int stall_run;
    bit stall_low;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
        n_errors++;
    endtask

    task automatic queue_word(input t_command c, input logic [ADDR_W-1:0] a,
                              input logic [DATA_W-1:0] d, input logic [DATA_W-1:0] v,
                              input bit drain);
        t_cmd_word w;
        w.cmd         = c;
        w.addr        = a;
        w.data        = d;
        w.in_val      = v;
        w.drain_first = drain;
        cmd_words_q.push_back(w);
        n_queued++;
    endtask

    // Random instruction byte, halt kept rare so programs run a while
    function automatic logic [DATA_W-1:0] random_instr();
        logic [OP_W-1:0] op;
        op = OP_W'($urandom_range(0, 7));
        if (op == OP_HALT && $urandom_range(0, 3) != 0)
            op = OP_W'($urandom_range(0, 6));
        return {op, ADDR_W'($urandom_range(0, MEM_WORDS - 1))};
    endfunction

    // Apply one command word to the shadow CPU and return the view it reports
    function automatic t_cpu_view cpu_after_word(input t_cmd_word w);
        t_cpu_view         r;
        logic [DATA_W-1:0] instr;
        logic [ADDR_W-1:0] opnd;
        t_opcode           op;
        r.took = 1'b0;
        case (w.cmd)
            CMD_WRITE: begin
                shadow_mem[w.addr] = w.data;
            end
            CMD_EXEC: begin
                if (!shadow_halt) begin
                    instr = shadow_mem[shadow_pc];
                    op    = t_opcode'(instr[DATA_W-1:ADDR_W]);
                    opnd  = instr[ADDR_W-1:0];
                    shadow_pc = shadow_pc + ADDR_W'(1);
                    n_exec++;
                    case (op)
                        OP_LOAD:  shadow_acc = shadow_mem[opnd];
                        OP_STORE: shadow_mem[opnd] = shadow_acc;
                        OP_ADD:   shadow_acc = shadow_acc + shadow_mem[opnd];
                        OP_SUB:   shadow_acc = shadow_acc - shadow_mem[opnd];
                        OP_INPUT: begin
                            shadow_acc = w.in_val;
                            r.took     = 1'b1;
                            n_inputs++;
                        end
                        OP_JZ: begin
                            if (shadow_acc == '0)
                                shadow_pc = opnd;
                        end
                        OP_JNN: begin
                            if (!shadow_acc[DATA_W-1])
                                shadow_pc = opnd;
                        end
                        default: begin
                            shadow_halt = 1'b1;
                            n_halts++;
                        end
                    endcase
                end
            end
            CMD_RESTART: begin
                shadow_pc   = '0;
                shadow_acc  = '0;
                shadow_halt = 1'b0;
            end
            default: ;
        endcase
        r.acc    = shadow_acc;
        r.pc     = shadow_pc;
        r.halted = shadow_halt;
        return r;
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run
    initial begin
        #3000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Drive command words: bursts and gaps, hold a word until taken
    always @(negedge i_clk) begin : drive_cmd_words
        t_cmd_word w;
        logic      v;
        v = in_bus.valid;
        if (!i_rst_n) begin
            v = 1'b0;
        end else if (!(in_bus.valid && n_taken != n_issued)) begin
            v = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (cmd_words_q.size() > 0 &&
                         !(cmd_words_q[0].drain_first && expected_views_q.size() != 0)) begin
                w = cmd_words_q.pop_front();
                in_bus.command     <= w.cmd;
                in_bus.address     <= w.addr;
                in_bus.data_byte   <= w.data;
                in_bus.input_value <= w.in_val;
                v = 1'b1;
                n_issued++;
                if (burst_left > 0) begin
                    burst_left--;
                end else if ($urandom_range(0, 4) == 0) begin
                    burst_left = $urandom_range(50, 200);
                    gap_left   = 0;
                end else begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = $urandom_range(1, 8);
                end
            end
        end
        in_bus.valid <= v;
    end

    // Stall the result channel on a changing pattern
    always @(negedge i_clk) begin : drive_result_ready
        logic r;
        if (stall_seg == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_seg  = $urandom_range(20, 120);
        end else begin
            stall_seg--;
        end
        stall_phase++;
        case (stall_mode)
            0: r = 1'b1;
            1: r = ($urandom_range(0, 3) != 0);
            2: r = ((stall_phase % 7) >= 3);
            default: begin
                if (stall_run == 0) begin
                    stall_low = ~stall_low;
                    stall_run = stall_low ? $urandom_range(1, 25) : $urandom_range(1, 10);
                end else begin
                    stall_run--;
                end
                r = !stall_low;
            end
        endcase
        out_bus.ready <= i_rst_n ? r : 1'b0;
    end

    // Predict on every accepted command word
    always @(posedge i_clk) begin : predict_words
        t_cmd_word w;
        if (!i_rst_n) begin
            foreach (shadow_mem[k])
                shadow_mem[k] = '0;
            shadow_acc  = '0;
            shadow_pc   = '0;
            shadow_halt = 1'b0;
        end else if (in_bus.valid && in_bus.ready) begin
            w.cmd         = t_command'(in_bus.command);
            w.addr        = in_bus.address;
            w.data        = in_bus.data_byte;
            w.in_val      = in_bus.input_value;
            w.drain_first = 1'b0;
            expected_views_q.push_back(cpu_after_word(w));
            n_taken++;
        end
    end

    // Check every accepted result word against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_cpu_view e;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            n_results++;
            if (expected_views_q.size() == 0) begin
                report_mismatch("result word with nothing expected", n_results, 0);
            end else begin
                e = expected_views_q.pop_front();
                if (out_bus.accumulator !== e.acc)
                    report_mismatch("accumulator", $signed(out_bus.accumulator),
                                    $signed(e.acc));
                if (out_bus.program_counter !== e.pc)
                    report_mismatch("program_counter", out_bus.program_counter, e.pc);
                if (out_bus.halted !== e.halted)
                    report_mismatch("halted", out_bus.halted, e.halted);
                if (out_bus.took_input !== e.took)
                    report_mismatch("took_input", out_bus.took_input, e.took);
            end
        end
    end

    // Build the stimulus, run it, and judge the result
    initial begin
        int  scen;
        int  len;
        int  runs;
        int  n_programs;
        bit  drain;

        i_rst_n             = 1'b0;
        in_bus.valid        = 1'b0;
        in_bus.command      = CMD_WRITE;
        in_bus.address      = '0;
        in_bus.data_byte    = '0;
        in_bus.input_value  = '0;
        out_bus.ready       = 1'b0;
        n_programs          = 0;

        // Data bytes, including the top address and an all-ones byte
        queue_word(CMD_WRITE, 5'd20, 8'h7f, 8'h00, 1'b0);
        queue_word(CMD_WRITE, 5'd21, 8'h80, 8'hff, 1'b0);
        queue_word(CMD_WRITE, 5'd22, 8'h01, 8'h00, 1'b0);
        queue_word(CMD_WRITE, 5'd31, 8'hff, 8'h7f, 1'b0);
        // Program: overflow on add and subtract, jumps taken and not, halt
        queue_word(CMD_WRITE, 5'd0, {OP_LOAD,  5'd20}, 8'h00, 1'b0);
        queue_word(CMD_WRITE, 5'd1, {OP_ADD,   5'd22}, 8'h00, 1'b0);
        queue_word(CMD_WRITE, 5'd2, {OP_JNN,   5'd0},  8'h00, 1'b0);
        queue_word(CMD_WRITE, 5'd3, {OP_SUB,   5'd22}, 8'h00, 1'b0);
        queue_word(CMD_WRITE, 5'd4, {OP_STORE, 5'd24}, 8'h00, 1'b0);
        queue_word(CMD_WRITE, 5'd5, {OP_INPUT, 5'd0},  8'h00, 1'b0);
        queue_word(CMD_WRITE, 5'd6, {OP_JZ,    5'd0},  8'h00, 1'b0);
        queue_word(CMD_WRITE, 5'd7, {OP_INPUT, 5'd0},  8'h00, 1'b0);
        queue_word(CMD_WRITE, 5'd8, {OP_JZ,    5'd10}, 8'h00, 1'b0);
        queue_word(CMD_WRITE, 5'd10, {OP_HALT, 5'd0},  8'h00, 1'b0);
        queue_word(CMD_EXEC, 5'd0, 8'h00, 8'h00, 1'b0);
        queue_word(CMD_EXEC, 5'd0, 8'h00, 8'h00, 1'b0);
        queue_word(CMD_EXEC, 5'd0, 8'h00, 8'h00, 1'b0);
        queue_word(CMD_EXEC, 5'd0, 8'h00, 8'h00, 1'b0);
        queue_word(CMD_EXEC, 5'd0, 8'h00, 8'h00, 1'b0);
        queue_word(CMD_EXEC, 5'd0, 8'h00, 8'h80, 1'b0);
        queue_word(CMD_EXEC, 5'd0, 8'h00, 8'h7f, 1'b0);
        queue_word(CMD_EXEC, 5'd0, 8'h00, 8'h00, 1'b0);
        queue_word(CMD_EXEC, 5'd0, 8'h00, 8'h00, 1'b0);
        queue_word(CMD_EXEC, 5'd0, 8'h00, 8'h00, 1'b0);
        // Execute and write while halted, unused command, then restart
        queue_word(CMD_EXEC, 5'd31, 8'hff, 8'hff, 1'b0);
        queue_word(CMD_WRITE, 5'd9, 8'h55, 8'haa, 1'b0);
        queue_word(CMD_NONE, 5'd31, 8'hff, 8'hff, 1'b0);
        queue_word(CMD_RESTART, 5'd0, 8'h00, 8'h00, 1'b0);

        // Random programs with noise and bare restarts in between
        while (n_queued < DIRECTED_WORDS + RANDOM_WORDS) begin
            scen = $urandom_range(0, 9);
            if (scen < 6) begin
                len = $urandom_range(3, 14);
                for (int i = 0; i < len; i++)
                    queue_word(CMD_WRITE, ADDR_W'(i), random_instr(),
                               DATA_W'($urandom_range(0, 255)), 1'b0);
                for (int i = 0; i < 3; i++)
                    queue_word(CMD_WRITE, ADDR_W'($urandom_range(0, MEM_WORDS - 1)),
                               DATA_W'($urandom_range(0, 255)),
                               DATA_W'($urandom_range(0, 255)), 1'b0);
                drain = (n_programs == 0) || ($urandom_range(0, 5) == 0);
                if (drain || $urandom_range(0, 3) != 0)
                    queue_word(CMD_RESTART, ADDR_W'($urandom_range(0, MEM_WORDS - 1)),
                               DATA_W'($urandom_range(0, 255)),
                               DATA_W'($urandom_range(0, 255)), drain);
                n_programs++;
                runs = $urandom_range(6, 40);
                for (int i = 0; i < runs; i++) begin
                    if ($urandom_range(0, 11) == 0)
                        queue_word(CMD_WRITE, ADDR_W'($urandom_range(0, MEM_WORDS - 1)),
                                   random_instr(), DATA_W'($urandom_range(0, 255)), 1'b0);
                    else
                        queue_word(CMD_EXEC, ADDR_W'($urandom_range(0, MEM_WORDS - 1)),
                                   DATA_W'($urandom_range(0, 255)),
                                   DATA_W'($urandom_range(0, 255)), 1'b0);
                end
            end else if (scen < 8) begin
                for (int i = 0; i < 8; i++)
                    queue_word(t_command'($urandom_range(0, 3)),
                               ADDR_W'($urandom_range(0, MEM_WORDS - 1)),
                               DATA_W'($urandom_range(0, 255)),
                               DATA_W'($urandom_range(0, 255)), 1'b0);
            end else begin
                queue_word(CMD_RESTART, '0, '0, '0, 1'b0);
                runs = $urandom_range(4, 20);
                for (int i = 0; i < runs; i++)
                    queue_word(CMD_EXEC, ADDR_W'($urandom_range(0, MEM_WORDS - 1)),
                               DATA_W'($urandom_range(0, 255)),
                               DATA_W'($urandom_range(0, 255)), 1'b0);
            end
        end

        // Hold reset, then release on a falling edge
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every word to go in and every result to come back
        while (cmd_words_q.size() != 0 || n_taken != n_issued || in_bus.valid)
            @(posedge i_clk);
        while (expected_views_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d command words over %0d programs:", n_taken, n_programs);
        $display("%0d instructions, %0d halts, %0d input reads, %0d result words checked.",
                 n_exec, n_halts, n_inputs, n_results);
        if (n_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/acc_pkg.sv
hw/rtl/acc_if.sv
hw/rtl/acc_ctrl.sv
hw/rtl/acc_dp.sv
hw/rtl/accumulator_cpu_step.sv
dv/tb_accumulator_cpu_step.sv
